/* sv/gms_pkg.sv */
// Package for the grid maze stack search block.
// Holds grid and stack sizes, command and status codes, and the payload types.
// No dependencies.
package gms_pkg;

  localparam int GridRows   = 16;
  localparam int GridCols   = 16;
  localparam int StackDepth = 256;
  localparam int RowW  = 4;
  localparam int ColW  = 4;
  localparam int CellW = RowW + ColW;
  localparam int SpW   = 9;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_NOPATH   = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_ENTRY    = 3'd3;
  localparam logic [2:0] ST_BEYOND   = 3'd4;

  localparam logic [2:0] CV_OPEN8   = 3'd0;
  localparam logic [2:0] CV_WALL    = 3'd1;
  localparam logic [2:0] CV_OPEN4   = 3'd2;
  localparam logic [2:0] CV_VISITED = 3'd3;
  localparam logic [2:0] CV_DEAD    = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic [1:0] cell_value;
    logic [7:0] path_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] path_length;
    logic [3:0] step_row;
    logic [3:0] step_col;
  } out_item_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic       load;        // write the input cell
    logic       start;       // reset search position and stack pointer
    logic       rd_cur;      // read current cell value
    logic       dir_clr;     // restart neighbor scan
    logic       rd_nb;       // read neighbor of current cell at scan index
    logic       push;        // mark current visited and push it, move to neighbor
    logic       dead;        // mark current dead
    logic       pop_rd;      // read top of stack
    logic       pop_wr;      // restore popped cell and move there
    logic       push_goal;   // push goal cell
    logic       fail;        // clear stack pointer
    logic       rd_path;     // read a path entry
  } gms_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic       at_goal;
    logic       cur_open8;
    logic       cur_open4;
    logic       nb_ok;       // neighbor inside grid and open (valid after rd_nb)
    logic       dir_last;
    logic       stack_full;
    logic       stack_empty;
  } gms_sts_t;

  function automatic logic signed [1:0] dr8(input logic [2:0] i);
    case (i)
      3'd0, 3'd2, 3'd3: dr8 = 2'sd1;
      3'd1, 3'd5:       dr8 = 2'sd0;
      default:          dr8 = -2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] dc8(input logic [2:0] i);
    case (i)
      3'd0, 3'd1, 3'd4: dc8 = 2'sd1;
      3'd2, 3'd6:       dc8 = 2'sd0;
      default:          dc8 = -2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] dr4(input logic [1:0] i);
    case (i)
      2'd1:    dr4 = 2'sd1;
      2'd2:    dr4 = -2'sd1;
      default: dr4 = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dc4(input logic [1:0] i);
    case (i)
      2'd0:    dc4 = 2'sd1;
      2'd3:    dc4 = -2'sd1;
      default: dc4 = 2'sd0;
    endcase
  endfunction

endpackage

/* sv/gms_datapath.sv */
// Datapath of the maze search: grid memory, path stack memory and search registers.
// Depends on gms_pkg.
module gms_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  gms_pkg::gms_cmd_t cmd,
  input  gms_pkg::in_item_t in_item,
  output gms_pkg::gms_sts_t sts,
  output logic [8:0]        sp_q,
  output logic [3:0]        entry_row,
  output logic [3:0]        entry_col
);

  logic [2:0]  maze_mem [gms_pkg::GridRows * gms_pkg::GridCols];
  logic [10:0] stack_mem [gms_pkg::StackDepth];

  logic [3:0]  cur_row_r, cur_row_nxt;
  logic [3:0]  cur_col_r, cur_col_nxt;
  logic [2:0]  cur_val_r;
  logic [2:0]  dir_r;
  logic [8:0]  sp_r, sp_nxt;
  logic [3:0]  nb_row_r, nb_col_r;
  logic [10:0] top_r;
  logic [2:0]  cell_r;
  logic        nb_ok_r;

  logic signed [5:0] nr, nc;
  logic        m_we;
  logic [7:0]  m_waddr, m_raddr;
  logic [2:0]  m_wdata;
  logic        m_re;

  always_comb begin
    if (cur_val_r == gms_pkg::CV_OPEN8) begin
      nr = $signed({2'b00, cur_row_r}) + 6'(gms_pkg::dr8(dir_r));
      nc = $signed({2'b00, cur_col_r}) + 6'(gms_pkg::dc8(dir_r));
    end else begin
      nr = $signed({2'b00, cur_row_r}) + 6'(gms_pkg::dr4(dir_r[1:0]));
      nc = $signed({2'b00, cur_col_r}) + 6'(gms_pkg::dc4(dir_r[1:0]));
    end
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = {cur_row_r, cur_col_r};
    m_wdata = gms_pkg::CV_VISITED;
    m_re    = cmd.rd_cur | cmd.rd_nb;
    m_raddr = cmd.rd_nb ? {nr[3:0], nc[3:0]} : {cur_row_r, cur_col_r};
    if (cmd.load) begin
      m_we    = 1'b1;
      m_waddr = {in_item.cell_row, in_item.cell_col};
      m_wdata = (in_item.cell_value == 2'd3) ? gms_pkg::CV_WALL : {1'b0, in_item.cell_value};
    end else if (cmd.push) begin
      m_we = 1'b1;
    end else if (cmd.dead) begin
      m_we    = 1'b1;
      m_wdata = gms_pkg::CV_DEAD;
    end else if (cmd.pop_wr) begin
      m_we    = 1'b1;
      m_waddr = top_r[10:3];
      m_wdata = top_r[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      maze_mem[m_waddr] <= m_wdata;
    end
    if (m_re) begin
      cell_r <= maze_mem[m_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[sp_r[7:0]] <= {cur_row_r, cur_col_r, cur_val_r};
    end else if (cmd.push_goal) begin
      stack_mem[sp_r[7:0]] <= {cur_row_r, cur_col_r, cell_r};
    end
    if (cmd.pop_rd) begin
      top_r <= stack_mem[sp_r[7:0] - 8'd1];
    end else if (cmd.rd_path) begin
      top_r <= stack_mem[in_item.path_index];
    end
  end

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    sp_nxt      = sp_r;
    if (cmd.start) begin
      cur_row_nxt = '0;
      cur_col_nxt = '0;
      sp_nxt      = '0;
    end else if (cmd.push) begin
      cur_row_nxt = nb_row_r;
      cur_col_nxt = nb_col_r;
      sp_nxt      = sp_r + 9'd1;
    end else if (cmd.push_goal) begin
      sp_nxt = sp_r + 9'd1;
    end else if (cmd.pop_wr) begin
      cur_row_nxt = top_r[10:7];
      cur_col_nxt = top_r[6:3];
      sp_nxt      = sp_r - 9'd1;
    end else if (cmd.fail) begin
      sp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      sp_r      <= '0;
      dir_r     <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      sp_r      <= sp_nxt;
      if (cmd.dir_clr) begin
        dir_r <= '0;
      end else if (cmd.rd_nb) begin
        dir_r <= dir_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_cur) begin
      cur_val_r <= maze_mem[{cur_row_r, cur_col_r}];
    end
    if (cmd.rd_nb) begin
      nb_row_r <= nr[3:0];
      nb_col_r <= nc[3:0];
      nb_ok_r  <= (nr >= 6'sd0) && (nr < 6'(gms_pkg::GridRows)) &&
                  (nc >= 6'sd0) && (nc < 6'(gms_pkg::GridCols));
    end
  end

  assign sts.at_goal     = (cur_row_r == 4'(gms_pkg::GridRows - 1)) &&
                           (cur_col_r == 4'(gms_pkg::GridCols - 1));
  assign sts.cur_open8   = cur_val_r == gms_pkg::CV_OPEN8;
  assign sts.cur_open4   = cur_val_r == gms_pkg::CV_OPEN4;
  assign sts.nb_ok       = nb_ok_r &&
                           (cell_r == gms_pkg::CV_OPEN8 || cell_r == gms_pkg::CV_OPEN4);
  assign sts.dir_last    = (cur_val_r == gms_pkg::CV_OPEN8) ? (dir_r == 3'd0)
                                                             : (dir_r == 3'd4);
  assign sts.stack_full  = sp_r >= 9'(gms_pkg::StackDepth);
  assign sts.stack_empty = sp_r == 9'd0;

  assign sp_q      = sp_r;
  assign entry_row = top_r[10:7];
  assign entry_col = top_r[6:3];

endmodule

/* sv/gms_ctrl.sv */
// Controller state machine of the maze search: handshakes, command decode, search sequence.
// Depends on gms_pkg.
module gms_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gms_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output gms_pkg::out_item_t out_item,
  output gms_pkg::gms_cmd_t  cmd,
  input  gms_pkg::gms_sts_t  sts,
  input  logic [8:0]         sp_q,
  input  logic [3:0]         entry_row,
  input  logic [3:0]         entry_col
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CUR   = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_NB    = 4'd3;
  localparam logic [3:0] S_NBCHK = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_RESTO = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_GOAL  = 4'd8;
  localparam logic [3:0] S_GOAL2 = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  gms_pkg::out_item_t out_r, out_nxt;
  logic [7:0]         pidx_r;
  logic [8:0]         plen_r, plen_nxt;
  logic               accept;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    plen_nxt      = plen_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.command)
            gms_pkg::CMD_LOAD: begin
              cmd.load = (32'(in_item.cell_row) < gms_pkg::GridRows) &&
                         (32'(in_item.cell_col) < gms_pkg::GridCols);
            end
            gms_pkg::CMD_SOLVE: begin
              cmd.start = 1'b1;
              state_nxt = S_CUR;
            end
            gms_pkg::CMD_READ: begin
              cmd.rd_path = 1'b1;
              state_nxt   = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_CUR: begin
        cmd.rd_cur  = 1'b1;
        cmd.dir_clr = 1'b1;
        state_nxt   = sts.at_goal ? S_GOAL : S_EVAL;
      end
      S_GOAL: begin
        cmd.rd_cur = 1'b1;
        cmd.rd_nb  = 1'b0;
        state_nxt  = S_GOAL2;
      end
      S_EVAL: begin
        if (!sts.cur_open8 && !sts.cur_open4) begin
          cmd.fail      = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = '{gms_pkg::ST_NOPATH, 9'd0, 4'd0, 4'd0};
          plen_nxt      = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        cmd.rd_nb = 1'b1;
        state_nxt = S_NBCHK;
      end
      S_NBCHK: begin
        if (sts.nb_ok) begin
          if (sts.stack_full) begin
            cmd.fail      = 1'b1;
            out_valid_nxt = 1'b1;
            out_nxt       = '{gms_pkg::ST_OVERFLOW, 9'd0, 4'd0, 4'd0};
            plen_nxt      = '0;
            state_nxt     = S_IDLE;
          end else begin
            cmd.push  = 1'b1;
            state_nxt = S_CUR;
          end
        end else if (!sts.dir_last) begin
          state_nxt = S_NB;
        end else begin
          cmd.dead = 1'b1;
          if (sts.stack_empty) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{gms_pkg::ST_NOPATH, 9'd0, 4'd0, 4'd0};
            plen_nxt      = '0;
            state_nxt     = S_IDLE;
          end else begin
            cmd.pop_rd = 1'b1;
            state_nxt  = S_POP;
          end
        end
      end
      S_POP: begin
        state_nxt = S_RESTO;
      end
      S_RESTO: begin
        cmd.pop_wr = 1'b1;
        state_nxt  = S_CUR;
      end
      S_GOAL2: begin
        if (sts.stack_full) begin
          cmd.fail      = 1'b1;
          out_nxt       = '{gms_pkg::ST_OVERFLOW, 9'd0, 4'd0, 4'd0};
          plen_nxt      = '0;
        end else begin
          cmd.push_goal = 1'b1;
          out_nxt       = '{gms_pkg::ST_FOUND, sp_q + 9'd1, 4'd0, 4'd0};
          plen_nxt      = sp_q + 9'd1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        if (9'(pidx_r) < plen_r) begin
          out_nxt = '{gms_pkg::ST_ENTRY, plen_r, entry_row, entry_col};
        end else begin
          out_nxt = '{gms_pkg::ST_BEYOND, plen_r, 4'd0, 4'd0};
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      plen_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      plen_r      <= plen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      pidx_r <= in_item.path_index;
    end
  end

endmodule

/* sv/grid_maze_stack_search.sv */
// Top level of the grid maze stack search block.
// Depends on gms_pkg, gms_ctrl and gms_datapath.
//
// A 16 by 16 maze is loaded one cell per transaction, then a solve transaction runs a
// depth-first search from the top-left to the bottom-right corner and returns one
// status transaction; read transactions return path cells in stack order. The next
// transaction is taken once any result has been taken. A solve holds the input for the
// length of the search; every neighbor probe and every pop goes through a registered
// read of the grid or stack memory.
module grid_maze_stack_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gms_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gms_pkg::out_item_t out_data
);

  gms_pkg::gms_cmd_t cmd;
  gms_pkg::gms_sts_t sts;
  logic [8:0] sp_q;
  logic [3:0] entry_row, entry_col;

  gms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_data),
    .cmd(cmd), .sts(sts), .sp_q(sp_q),
    .entry_row(entry_row), .entry_col(entry_col)
  );

  gms_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_data), .sts(sts),
    .sp_q(sp_q), .entry_row(entry_row), .entry_col(entry_col)
  );

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for grid_maze_stack_search: loads mazes, solves them and reads paths.
// Expected results come from a behavioral depth-first search kept in this file.
// Depends on gms_pkg and the grid_maze_stack_search RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int WatchdogLimit = 400000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int VAL_ALT_WALL = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  gms_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gms_pkg::out_item_t out_data;

  always #6 clk = ~clk;

  grid_maze_stack_search u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  logic [2:0] grid [gms_pkg::GridRows*gms_pkg::GridCols];
  logic [3:0] trail_row [gms_pkg::StackDepth];
  logic [3:0] trail_col [gms_pkg::StackDepth];
  logic [2:0] trail_orig [gms_pkg::StackDepth];
  int unsigned trail_len;
  gms_pkg::out_item_t expected_q [$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_receiver = 1'b0;

  function automatic bit open_cell(int r, int c);
    if (r < 0 || c < 0 || r >= gms_pkg::GridRows || c >= gms_pkg::GridCols) return 1'b0;
    return grid[r*gms_pkg::GridCols+c] == gms_pkg::CV_OPEN8 ||
           grid[r*gms_pkg::GridCols+c] == gms_pkg::CV_OPEN4;
  endfunction

  function automatic bit stack_cell(int r, int c, logic [2:0] v);
    if (trail_len >= gms_pkg::StackDepth) return 1'b0;
    trail_row[trail_len] = 4'(r);
    trail_col[trail_len] = 4'(c);
    trail_orig[trail_len] = v;
    trail_len++;
    return 1'b1;
  endfunction

  function automatic logic [2:0] search_maze();
    int r, c, n, nr, nc;
    logic [2:0] v;
    bit moved;
    int d8r [8] = '{1, 0, 1, 1, -1, 0, -1, -1};
    int d8c [8] = '{1, 1, 0, -1, 1, -1, 0, -1};
    int d4r [4] = '{0, 1, -1, 0};
    int d4c [4] = '{1, 0, 0, -1};
    trail_len = 0;
    r = 0;
    c = 0;
    forever begin
      v = grid[r*gms_pkg::GridCols+c];
      if (r == gms_pkg::GridRows-1 && c == gms_pkg::GridCols-1)
        return stack_cell(r, c, v) ? gms_pkg::ST_FOUND : gms_pkg::ST_OVERFLOW;
      if (v == gms_pkg::CV_OPEN8) n = 8;
      else if (v == gms_pkg::CV_OPEN4) n = 4;
      else return gms_pkg::ST_NOPATH;
      moved = 1'b0;
      for (int i = 0; i < n && !moved; i++) begin
        nr = r + ((n == 8) ? d8r[i] : d4r[i]);
        nc = c + ((n == 8) ? d8c[i] : d4c[i]);
        if (open_cell(nr, nc)) begin
          grid[r*gms_pkg::GridCols+c] = gms_pkg::CV_VISITED;
          if (!stack_cell(r, c, v)) return gms_pkg::ST_OVERFLOW;
          r = nr;
          c = nc;
          moved = 1'b1;
        end
      end
      if (!moved) begin
        grid[r*gms_pkg::GridCols+c] = gms_pkg::CV_DEAD;
        if (trail_len == 0) return gms_pkg::ST_NOPATH;
        trail_len--;
        r = trail_row[trail_len];
        c = trail_col[trail_len];
        grid[r*gms_pkg::GridCols+c] = trail_orig[trail_len];
      end
    end
  endfunction

  function automatic void predict_maze(gms_pkg::in_item_t it);
    gms_pkg::out_item_t res;
    res = '0;
    case (it.command)
      gms_pkg::CMD_LOAD: begin
        grid[it.cell_row*gms_pkg::GridCols+it.cell_col] =
          (it.cell_value == 2'(VAL_ALT_WALL)) ? gms_pkg::CV_WALL : {1'b0, it.cell_value};
      end
      gms_pkg::CMD_SOLVE: begin
        res.status = search_maze();
        if (res.status != gms_pkg::ST_FOUND) trail_len = 0;
        res.path_length = 9'(trail_len);
        expected_q.push_back(res);
      end
      gms_pkg::CMD_READ: begin
        res.path_length = 9'(trail_len);
        if (it.path_index < trail_len) begin
          res.status = gms_pkg::ST_ENTRY;
          res.step_row = trail_row[it.path_index];
          res.step_col = trail_col[it.path_index];
        end else begin
          res.status = gms_pkg::ST_BEYOND;
        end
        expected_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(gms_pkg::in_item_t it);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_maze(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic gms_pkg::in_item_t make_item(logic [1:0] cmd, int r, int c, int v, int p);
    gms_pkg::in_item_t it;
    it.command = cmd;
    it.cell_row = 4'(r);
    it.cell_col = 4'(c);
    it.cell_value = 2'(v);
    it.path_index = 8'(p);
    return it;
  endfunction

  // Reload count random cells, then both corners; open_pct sets how sparse the walls are.
  task automatic load_maze(int count, int open_pct, int four_pct, bit block_start);
    int v;
    int r;
    int c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, gms_pkg::GridRows-1);
      c = $urandom_range(0, gms_pkg::GridCols-1);
      if ($urandom_range(0, 99) >= open_pct)
        v = ($urandom_range(0, 1) != 0) ? VAL_ALT_WALL : int'(gms_pkg::CV_WALL);
      else
        v = ($urandom_range(0, 99) < four_pct) ? int'(gms_pkg::CV_OPEN4)
                                                : int'(gms_pkg::CV_OPEN8);
      send_item(make_item(gms_pkg::CMD_LOAD, r, c, v, $urandom_range(0, 255)));
    end
    v = block_start ? int'(gms_pkg::CV_WALL) : int'(gms_pkg::CV_OPEN8);
    send_item(make_item(gms_pkg::CMD_LOAD, 0, 0, v, 0));
    send_item(make_item(gms_pkg::CMD_LOAD, gms_pkg::GridRows-1, gms_pkg::GridCols-1, v, 0));
  endtask

  task automatic read_path(int count);
    for (int i = 0; i < count; i++)
      send_item(make_item(gms_pkg::CMD_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 3),
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                          : $urandom_range(0, trail_len)));
  endtask

  typedef struct {
    gms_pkg::in_item_t  item;
    bit                 has_result;
    gms_pkg::out_item_t result;
  } directed_row_t;

  initial begin
    directed_row_t rows [6];
    rows[0] = '{make_item(gms_pkg::CMD_READ, 0, 0, 0, 0), 1'b1,
                '{gms_pkg::ST_BEYOND, 9'd0, 4'd0, 4'd0}};
    rows[1] = '{make_item(gms_pkg::CMD_READ, 15, 15, 3, 255), 1'b1,
                '{gms_pkg::ST_BEYOND, 9'd0, 4'd0, 4'd0}};
    rows[2] = '{make_item(CMD_UNUSED, 15, 15, 3, 255), 1'b0,
                '{3'd0, 9'd0, 4'd0, 4'd0}};
    rows[3] = '{make_item(gms_pkg::CMD_LOAD, 0, 0, VAL_ALT_WALL, 0), 1'b0,
                '{3'd0, 9'd0, 4'd0, 4'd0}};
    rows[4] = '{make_item(gms_pkg::CMD_SOLVE, 0, 0, 0, 0), 1'b0,
                '{3'd0, 9'd0, 4'd0, 4'd0}};
    rows[5] = '{make_item(gms_pkg::CMD_READ, 0, 0, 0, 0), 1'b1,
                '{gms_pkg::ST_BEYOND, 9'd0, 4'd0, 4'd0}};
    trail_len = 0;
    foreach (grid[i]) begin
      grid[i] = gms_pkg::CV_OPEN8;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // A full open grid first, so that every later solve runs over loaded cells.
    for (int i = 0; i < gms_pkg::GridRows*gms_pkg::GridCols; i++)
      send_item(make_item(gms_pkg::CMD_LOAD, i / gms_pkg::GridCols, i % gms_pkg::GridCols,
                          0, 0));
    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].has_result) expected_q[$] = rows[i].result;
    end
    drain_results();
    load_maze(40, 100, 0, 1'b0);
    send_item(make_item(gms_pkg::CMD_SOLVE, 0, 0, 0, 0));
    read_path(4);
    send_item(make_item(gms_pkg::CMD_SOLVE, 0, 0, 0, 0));
    drain_results();
    hold_receiver = 1'b1;
    load_maze(40, 80, 30, 1'b0);
    send_item(make_item(gms_pkg::CMD_SOLVE, 0, 0, 0, 0));
    read_path(8);
    hold_receiver = 1'b0;
    drain_results();
    for (int m = 0; m < 10; m++) begin
      if (m == 8) no_idle = 1'b1;
      load_maze(25, (m % 3 == 0) ? 95 : $urandom_range(55, 85), $urandom_range(0, 100),
                m == 4);
      send_item(make_item(gms_pkg::CMD_SOLVE, 0, 0, 0, 0));
      read_path($urandom_range(3, 10));
      if (m % 4 == 1) begin
        send_item(make_item(gms_pkg::CMD_SOLVE, 0, 0, 0, 0));
        read_path(2);
      end
      send_item(make_item(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 3), $urandom_range(0, 255)));
    end
    drain_results();
    if (fail_count == 0)
      $display("grid_maze_stack_search regression: pass");
    else
      $display("grid_maze_stack_search regression: fail");
    $finish;
  end

  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_ready <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        hold_receiver = 1'b0;
      end
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    gms_pkg::out_item_t want;
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.status !== want.status || out_data.path_length !== want.path_length ||
            out_data.step_row !== want.step_row || out_data.step_col !== want.step_col) begin
          $display("%0t mismatch expected %p actual %p", $time, want, out_data);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("grid_maze_stack_search regression: fail");
      $finish;
    end
  end

endmodule

/* files.f */
sv/gms_pkg.sv
sv/gms_datapath.sv
sv/gms_ctrl.sv
sv/grid_maze_stack_search.sv
bench/tb_top.sv
